/* sv/assert_macros.svh */
// Assertion helpers for the RTL files; only the table core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication-style property on the rising edge of clk, off in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds on every rising edge of clk, off in reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

/* sv/lrutp_pkg.sv */
// ----------------------------------------------------------------------------
// lrutp_pkg
// Request and status codes, field widths and controller states of the
// LRU table with pinning.
// ----------------------------------------------------------------------------
`default_nettype none

package lrutp_pkg;

    localparam int KEY_W   = 32;
    localparam int TIN_W   = 48;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CNTO_W  = 7;
    localparam int MAX_OUT = 64;

    localparam logic [REQ_W-1:0] REQ_TOUCH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PIN   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LIST  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RSVD  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MISS,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_APPEND,
        ST_RESP,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SA_RD,
        ST_SA_LD,
        ST_SB_RD,
        ST_SB_CMP,
        ST_SA_WR,
        ST_OUT_RD,
        ST_OUT_SLOT,
        ST_OUT_EMIT
    } state_t;

endpackage

`default_nettype wire

/* sv/lru_table_with_pinning_core.sv */
// ----------------------------------------------------------------------------
// lru_table_with_pinning_core
// Touch and pin: accept, then a read and a check per scanned slot (scan stops
//   at a hit), then respond; a miss adds a miss step, an append a write, an
//   eviction a read and a write per shifted slot, up to ENTRIES-1 slots.
// List: copy all n entries into the rank memory, run a sort pass for each rank
//   a < min(k,n,MAX_OUT), then read and emit each; an empty list just responds.
// One request at a time; rst_n low (async) clears the table, state and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_table_with_pinning_core #(
    parameter int ENTRIES   = 64,
    parameter int TIME_BITS = 48
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [lrutp_pkg::REQ_W-1:0]    req_type,
    input  wire logic [lrutp_pkg::KEY_W-1:0]    key,
    input  wire logic [lrutp_pkg::TIN_W-1:0]    time_ms,
    input  wire logic                           pin_value,
    input  wire logic [lrutp_pkg::CNTO_W-1:0]   top_count,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [lrutp_pkg::STAT_W-1:0]        status,
    output logic                                entry_valid,
    output logic [lrutp_pkg::KEY_W-1:0]         entry_key,
    output logic                                entry_pinned,
    output logic [lrutp_pkg::CNTO_W-1:0]        entry_count,
    output logic                                last
);
    import lrutp_pkg::*;
    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    // loop counters must hold both the entry count and the 7-bit request size
    localparam int CW    = (CNT_W > CNTO_W) ? CNT_W : CNTO_W;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [TIME_BITS-1:0] tstamp;
        logic                 pinned;
    } slot_t;

    // rank entries carry a copy of the sort key so the sort needs one read per step
    typedef struct packed {
        logic [IDX_W-1:0]     idx;
        logic                 pinned;
        logic [TIME_BITS-1:0] tstamp;
    } rank_t;

    // ------------------------------------------------------------------------
    // Memories: one read port with registered data, one write port each
    // ------------------------------------------------------------------------
    slot_t slot_mem [ENTRIES];
    rank_t rank_mem [ENTRIES];

    logic              slot_re, slot_we, rank_re, rank_we;
    logic [IDX_W-1:0]  slot_raddr, slot_waddr, rank_raddr, rank_waddr;
    slot_t             slot_wdata, slot_rd;
    rank_t             rank_wdata, rank_rd;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_rd <= slot_mem[slot_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        if (rank_re)
        begin
            rank_rd <= rank_mem[rank_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // Control and request registers
    // ------------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          a_reg, a_next;
    logic [CW-1:0]          lim_reg, lim_next;
    logic                   vfound_reg, vfound_next;
    logic [IDX_W-1:0]       victim_reg, victim_next;
    logic [TIME_BITS-1:0]   oldest_reg, oldest_next;
    logic [REQ_W-1:0]       req_reg, req_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [TIME_BITS-1:0]   now_reg, now_next;
    logic                   pin_reg, pin_next;
    logic [STAT_W-1:0]      stat_reg, stat_next;
    rank_t                  x_reg, x_next;

    // result register toward the output channel
    logic                   out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]      res_status_reg, res_status_next;
    logic                   res_ev_reg, res_ev_next;
    logic [KEY_W-1:0]       res_key_reg, res_key_next;
    logic                   res_pin_reg, res_pin_next;
    logic [CNTO_W-1:0]      res_count_reg, res_count_next;
    logic                   res_last_reg, res_last_next;

    logic                   out_free;
    logic [CW-1:0]          count_w, lim0, want_w;
    logic                   key_hit, better;
    logic                   mem_wr_any, in_append;

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign count_w    = CW'(count_reg);
    assign want_w     = CW'(top_count);
    assign key_hit    = (slot_rd.key == key_reg);
    assign better     = (rank_rd.pinned && !x_reg.pinned) ||
                        ((rank_rd.pinned == x_reg.pinned) && (rank_rd.tstamp > x_reg.tstamp));
    assign mem_wr_any = slot_we || rank_we;
    assign in_append  = (state_reg == ST_APPEND);

    // listing length: min of request, held entries and result limit
    always_comb
    begin
        lim0 = (want_w < count_w) ? want_w : count_w;
        if (lim0 > CW'(MAX_OUT))
        begin
            lim0 = CW'(MAX_OUT);
        end
    end

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_TOUCH, REQ_PIN:
                            state_next = (count_reg == '0) ? ST_MISS : ST_SCAN_RD;
                        REQ_LIST:
                            state_next = (lim0 == '0) ? ST_RESP : ST_COPY_RD;
                        default:
                            state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN_RD:  state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (key_hit)
                begin
                    state_next = ST_RESP;
                end
                else if (idx_reg + 1'b1 == count_w)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MISS:
            begin
                if (req_reg == REQ_PIN)
                begin
                    state_next = ST_RESP;
                end
                else if (32'(count_reg) < ENTRIES)
                begin
                    state_next = ST_APPEND;
                end
                else if (!vfound_reg)
                begin
                    state_next = ST_RESP;
                end
                else if (32'(victim_reg) == ENTRIES - 1)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: state_next = ST_SHIFT_WR;
            ST_SHIFT_WR:
                state_next = (32'(idx_reg) + 2 < ENTRIES) ? ST_SHIFT_RD : ST_APPEND;
            ST_APPEND:   state_next = ST_RESP;
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COPY_RD:  state_next = ST_COPY_WR;
            ST_COPY_WR:
                state_next = (idx_reg + 1'b1 == count_w) ? ST_SA_RD : ST_COPY_RD;
            ST_SA_RD:    state_next = ST_SA_LD;
            ST_SA_LD:
                state_next = (a_reg + 1'b1 == count_w) ? ST_SA_WR : ST_SB_RD;
            ST_SB_RD:    state_next = ST_SB_CMP;
            ST_SB_CMP:
                state_next = (idx_reg + 1'b1 == count_w) ? ST_SA_WR : ST_SB_RD;
            ST_SA_WR:
                state_next = (a_reg + 1'b1 == lim_reg) ? ST_OUT_RD : ST_SA_RD;
            ST_OUT_RD:   state_next = ST_OUT_SLOT;
            ST_OUT_SLOT: state_next = ST_OUT_EMIT;
            ST_OUT_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (idx_reg + 1'b1 == lim_reg) ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------------
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        a_next          = a_reg;
        lim_next        = lim_reg;
        vfound_next     = vfound_reg;
        victim_next     = victim_reg;
        oldest_next     = oldest_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        pin_next        = pin_reg;
        stat_next       = stat_reg;
        x_next          = x_reg;
        res_status_next = res_status_reg;
        res_ev_next     = res_ev_reg;
        res_key_next    = res_key_reg;
        res_pin_next    = res_pin_reg;
        res_count_next  = res_count_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && out_stall;

        slot_re    = 1'b0;
        slot_raddr = idx_reg[IDX_W-1:0];
        slot_we    = 1'b0;
        slot_waddr = idx_reg[IDX_W-1:0];
        slot_wdata = slot_rd;
        rank_re    = 1'b0;
        rank_raddr = idx_reg[IDX_W-1:0];
        rank_we    = 1'b0;
        rank_waddr = idx_reg[IDX_W-1:0];
        rank_wdata = x_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = req_type;
                    key_next    = key;
                    now_next    = TIME_BITS'(time_ms);
                    pin_next    = pin_value;
                    lim_next    = lim0;
                    idx_next    = '0;
                    a_next      = '0;
                    vfound_next = 1'b0;
                    stat_next   = STAT_OK;
                end
            end
            ST_SCAN_RD:
            begin
                slot_re = 1'b1;
            end
            ST_SCAN_CHK:
            begin
                if (key_hit)
                begin
                    // hit: write back the refreshed time or the new pin mark
                    slot_we = 1'b1;
                    if (req_reg == REQ_PIN)
                    begin
                        slot_wdata.pinned = pin_reg;
                    end
                    else
                    begin
                        slot_wdata.tstamp = now_reg;
                    end
                end
                else
                begin
                    // track the first unpinned slot with the least time
                    if (!slot_rd.pinned && (!vfound_reg || slot_rd.tstamp < oldest_reg))
                    begin
                        vfound_next = 1'b1;
                        oldest_next = slot_rd.tstamp;
                        victim_next = idx_reg[IDX_W-1:0];
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MISS:
            begin
                if (req_reg == REQ_PIN)
                begin
                    stat_next = STAT_NOTFOUND;
                end
                else if (32'(count_reg) >= ENTRIES)
                begin
                    if (!vfound_reg)
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        idx_next   = CW'(victim_reg);
                    end
                end
            end
            ST_SHIFT_RD:
            begin
                slot_re    = 1'b1;
                slot_raddr = IDX_W'(idx_reg + 1'b1);
            end
            ST_SHIFT_WR:
            begin
                slot_we  = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            ST_APPEND:
            begin
                slot_we    = 1'b1;
                slot_waddr = count_reg[IDX_W-1:0];
                slot_wdata = '{key: key_reg, tstamp: now_reg, pinned: 1'b0};
                count_next = count_reg + 1'b1;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    res_status_next = stat_reg;
                    res_ev_next     = 1'b0;
                    res_key_next    = '0;
                    res_pin_next    = 1'b0;
                    res_count_next  = CNTO_W'(count_reg);
                    res_last_next   = 1'b1;
                end
            end
            ST_COPY_RD:
            begin
                slot_re = 1'b1;
            end
            ST_COPY_WR:
            begin
                rank_we    = 1'b1;
                rank_wdata = '{idx: idx_reg[IDX_W-1:0], pinned: slot_rd.pinned,
                               tstamp: slot_rd.tstamp};
                idx_next   = idx_reg + 1'b1;
            end
            ST_SA_RD:
            begin
                rank_re    = 1'b1;
                rank_raddr = a_reg[IDX_W-1:0];
            end
            ST_SA_LD:
            begin
                x_next   = rank_rd;
                idx_next = a_reg + 1'b1;
            end
            ST_SB_RD:
            begin
                rank_re = 1'b1;
            end
            ST_SB_CMP:
            begin
                // exchange when the later entry ranks strictly higher
                if (better)
                begin
                    rank_we = 1'b1;
                    x_next  = rank_rd;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_SA_WR:
            begin
                rank_we    = 1'b1;
                rank_waddr = a_reg[IDX_W-1:0];
                a_next     = a_reg + 1'b1;
                idx_next   = '0;
            end
            ST_OUT_RD:
            begin
                rank_re = 1'b1;
            end
            ST_OUT_SLOT:
            begin
                slot_re    = 1'b1;
                slot_raddr = rank_rd.idx;
            end
            ST_OUT_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    res_status_next = STAT_OK;
                    res_ev_next     = 1'b1;
                    res_key_next    = slot_rd.key;
                    res_pin_next    = slot_rd.pinned;
                    res_count_next  = CNTO_W'(count_reg);
                    res_last_next   = (idx_reg + 1'b1 == lim_reg);
                    idx_next        = idx_reg + 1'b1;
                end
            end
            default:
            begin
                stat_next = STAT_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        a_reg          <= a_next;
        lim_reg        <= lim_next;
        vfound_reg     <= vfound_next;
        victim_reg     <= victim_next;
        oldest_reg     <= oldest_next;
        req_reg        <= req_next;
        key_reg        <= key_next;
        now_reg        <= now_next;
        pin_reg        <= pin_next;
        stat_reg       <= stat_next;
        x_reg          <= x_next;
        res_status_reg <= res_status_next;
        res_ev_reg     <= res_ev_next;
        res_key_reg    <= res_key_next;
        res_pin_reg    <= res_pin_next;
        res_count_reg  <= res_count_next;
        res_last_reg   <= res_last_next;
    end

    // drive the output channel straight from the result register
    assign out_valid    = out_valid_reg;
    assign status       = res_status_reg;
    assign entry_valid  = res_ev_reg;
    assign entry_key    = res_key_reg;
    assign entry_pinned = res_pin_reg;
    assign entry_count  = res_count_reg;
    assign last         = res_last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_ALWAYS(a_count_bound, 32'(count_reg) <= ENTRIES, "entry count above table size")
    `ASSERT_ALWAYS(a_idle_no_write, (state_reg != ST_IDLE) || !mem_wr_any, "write while idle")
    `ASSERT_CLK(a_append_inc, in_append |=> (count_reg == $past(count_reg) + 1'b1), "count stuck")

endmodule

`default_nettype wire

/* bench/lru_table_with_pinning_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_table_with_pinning_core_test
// Drives touch, pin, list and reserved requests into the LRU table with random gaps and
// output stalls, predicts every result from a local model of the table and
// compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_table_with_pinning_core_test;

    import lrutp_pkg::*;

    localparam int ENTRIES   = 64;
    localparam int CYC_LIMIT = 10000000;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [KEY_W-1:0]  k;
        logic [TIN_W-1:0]  t;
        logic              pin;
        logic [CNTO_W-1:0] want;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic              ev;
        logic [KEY_W-1:0]  ek;
        logic              ep;
        logic [CNTO_W-1:0] cnt;
        logic              lst;
    } reply_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [REQ_W-1:0] req_type = '0;
    logic [KEY_W-1:0] key = '0;
    logic [TIN_W-1:0] time_ms = '0;
    logic pin_value = 1'b0;
    logic [CNTO_W-1:0] top_count = '0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic [STAT_W-1:0] status;
    logic entry_valid;
    logic [KEY_W-1:0] entry_key;
    logic entry_pinned;
    logic [CNTO_W-1:0] entry_count;
    logic last;

    lru_table_with_pinning_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .key(key), .time_ms(time_ms),
        .pin_value(pin_value), .top_count(top_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .entry_valid(entry_valid), .entry_key(entry_key),
        .entry_pinned(entry_pinned), .entry_count(entry_count), .last(last)
    );

    always #2 clk = ~clk;

    // Local copy of the table that the predictions are worked out from.
    logic [KEY_W-1:0] tbl_key [ENTRIES];
    logic [TIN_W-1:0] tbl_time [ENTRIES];
    logic             tbl_pin [ENTRIES];
    int               tbl_n = 0;

    request_t pending_reqs[$];
    reply_t   expected_replies[$];
    int  fails = 0;
    logic stim_done = 1'b0;
    logic quiet_in = 1'b0;
    int  cycles = 0;
    logic [KEY_W-1:0] key_pool[$];

    function automatic reply_t mk(logic [STAT_W-1:0] st, logic ev, logic [KEY_W-1:0] ek,
                                  logic ep, logic lst);
        reply_t r;
        r.st = st; r.ev = ev; r.ek = ek; r.ep = ep; r.cnt = CNTO_W'(tbl_n); r.lst = lst;
        return r;
    endfunction

    function automatic int lookup(logic [KEY_W-1:0] k);
        for (int i = 0; i < tbl_n; i++)
            if (tbl_key[i] == k) return i;
        return -1;
    endfunction

    // Apply one request to the table model and queue its replies.
    task automatic predict_table(request_t r);
        int s, victim, lim;
        logic found;
        logic [TIN_W-1:0] oldest;
        int order [ENTRIES];
        int x, y;
        s = lookup(r.k);
        case (r.req)
            REQ_TOUCH:
            begin
                if (s >= 0)
                begin
                    tbl_time[s] = r.t;
                    expected_replies.push_back(mk(STAT_OK, 0, 0, 0, 1));
                end
                else
                begin
                    found = 0; victim = 0; oldest = '0;
                    if (tbl_n >= ENTRIES)
                    begin
                        for (int i = 0; i < tbl_n; i++)
                            if (!tbl_pin[i] && (!found || tbl_time[i] < oldest))
                            begin
                                found = 1; oldest = tbl_time[i]; victim = i;
                            end
                        if (!found)
                        begin
                            expected_replies.push_back(mk(STAT_FULL, 0, 0, 0, 1));
                            return;
                        end
                        for (int i = victim; i + 1 < tbl_n; i++)
                        begin
                            tbl_key[i] = tbl_key[i+1];
                            tbl_time[i] = tbl_time[i+1];
                            tbl_pin[i] = tbl_pin[i+1];
                        end
                        tbl_n--;
                    end
                    tbl_key[tbl_n] = r.k; tbl_time[tbl_n] = r.t; tbl_pin[tbl_n] = 0;
                    tbl_n++;
                    expected_replies.push_back(mk(STAT_OK, 0, 0, 0, 1));
                end
            end
            REQ_PIN:
            begin
                if (s < 0)
                    expected_replies.push_back(mk(STAT_NOTFOUND, 0, 0, 0, 1));
                else
                begin
                    tbl_pin[s] = r.pin;
                    expected_replies.push_back(mk(STAT_OK, 0, 0, 0, 1));
                end
            end
            REQ_LIST:
            begin
                for (int i = 0; i < tbl_n; i++) order[i] = i;
                for (int a = 0; a < tbl_n; a++)
                    for (int b = a + 1; b < tbl_n; b++)
                    begin
                        x = order[a]; y = order[b];
                        if (tbl_pin[y] > tbl_pin[x] ||
                            (tbl_pin[y] == tbl_pin[x] && tbl_time[y] > tbl_time[x]))
                        begin
                            order[a] = y; order[b] = x;
                        end
                    end
                lim = (int'(r.want) < tbl_n) ? int'(r.want) : tbl_n;
                if (lim > MAX_OUT) lim = MAX_OUT;
                if (lim == 0)
                    expected_replies.push_back(mk(STAT_OK, 0, 0, 0, 1));
                for (int i = 0; i < lim; i++)
                    expected_replies.push_back(mk(STAT_OK, 1, tbl_key[order[i]],
                                                  tbl_pin[order[i]], i + 1 == lim));
            end
            default:
                expected_replies.push_back(mk(STAT_OK, 0, 0, 0, 1));
        endcase
    endtask

    function automatic request_t make_req(logic [REQ_W-1:0] rq, logic [KEY_W-1:0] k,
                                          logic [TIN_W-1:0] t, logic p,
                                          logic [CNTO_W-1:0] w);
        request_t r;
        r.req = rq; r.k = k; r.t = t; r.pin = p; r.want = w;
        return r;
    endfunction

    // Keys mostly come from a small pool so hits, pins and evictions are common.
    function automatic logic [KEY_W-1:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(0, 99) < 75)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom();
    endfunction

    initial
    begin
        logic [KEY_W-1:0] k;
        logic [TIN_W-1:0] t;
        int c;
        // Directed: empty list, unused request, missing pin, touches, pin and unpin, lists of 0, 1 and 127.
        pending_reqs.push_back(make_req(REQ_LIST, 0, 0, 0, 7'd64));
        pending_reqs.push_back(make_req(REQ_RSVD, '1, '1, 1, '1));
        pending_reqs.push_back(make_req(REQ_PIN, 32'h1234, 0, 1, 0));
        pending_reqs.push_back(make_req(REQ_TOUCH, 32'h0, '0, 0, 0));
        pending_reqs.push_back(make_req(REQ_TOUCH, '1, '1, 1, '1));
        pending_reqs.push_back(make_req(REQ_TOUCH, 32'h0, 48'h5, 0, 0));
        pending_reqs.push_back(make_req(REQ_PIN, '1, 0, 1, 0));
        pending_reqs.push_back(make_req(REQ_LIST, 0, 0, 0, 7'd0));
        pending_reqs.push_back(make_req(REQ_LIST, 0, 0, 0, 7'd1));
        pending_reqs.push_back(make_req(REQ_LIST, 0, 0, 0, 7'd127));
        pending_reqs.push_back(make_req(REQ_PIN, '1, 0, 0, 0));
        // Fill the table, then pin the new keys; two old keys stay unpinned.
        for (int i = 0; i < ENTRIES; i++)
            pending_reqs.push_back(make_req(REQ_TOUCH, 32'h100 + i, 48'(i), 0, 0));
        for (int i = 0; i < ENTRIES; i++)
            pending_reqs.push_back(make_req(REQ_PIN, 32'h100 + i, 0, 1, 0));
        pending_reqs.push_back(make_req(REQ_TOUCH, 32'hdead, 48'h9, 0, 0));
        pending_reqs.push_back(make_req(REQ_PIN, 32'h120, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_PIN, 32'h130, 0, 0, 0));
        pending_reqs.push_back(make_req(REQ_TOUCH, 32'hbeef, 48'h9, 0, 0));
        pending_reqs.push_back(make_req(REQ_LIST, 0, 0, 0, 7'd64));
        for (int i = 0; i < 40; i++) key_pool.push_back($urandom());
        for (int i = 0; i < 216; i++)
        begin
            c = $urandom_range(0, 99);
            k = pick_key();
            t = 48'({$urandom(), $urandom()});
            if ($urandom_range(0, 3) == 0) t = 48'($urandom_range(0, 7));
            if (c < 55)
                pending_reqs.push_back(make_req(REQ_TOUCH, k, t, 1'($urandom()),
                                                7'($urandom())));
            else if (c < 78)
                pending_reqs.push_back(make_req(REQ_PIN, k, t, 1'($urandom()),
                                                7'($urandom())));
            else if (c < 97)
                pending_reqs.push_back(make_req(REQ_LIST, k, t, 1'($urandom()),
                    ($urandom_range(0, 4) == 0) ? 7'($urandom()) :
                                                  7'($urandom_range(0, 6))));
            else
                pending_reqs.push_back(make_req(REQ_RSVD, k, t, 1'($urandom()),
                                                7'($urandom())));
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: hold the payload while stalled, advance on a transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_table(make_req(req_type, key, time_ms, pin_value, top_count));
                void'(pending_reqs.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_reqs.size() > 0 &&
                    (quiet_in || $urandom_range(0, 99) >= 28))
                begin
                    in_valid  <= 1'b1;
                    req_type  <= pending_reqs[0].req;
                    key       <= pending_reqs[0].k;
                    time_ms   <= pending_reqs[0].t;
                    pin_value <= pending_reqs[0].pin;
                    top_count <= pending_reqs[0].want;
                end
                else
                    in_valid <= 1'b0;
            end
            if (pending_reqs.size() == 0 && !(in_valid && in_stall))
                stim_done <= 1'b1;
        end
    end

    // Receiver stall pattern: a long hold-off early, quiet stretches later.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        quiet_in <= (cycles % 4000) > 3000;
        if (!rst_n)
            out_stall <= 1'b1;
        else if (cycles > 300 && cycles < 900)
            out_stall <= 1'b1;
        else if ((cycles % 4000) > 3000)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 28);
    end

    // Monitor: compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        reply_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.st = status; got.ev = entry_valid; got.ek = entry_key;
            got.ep = entry_pinned; got.cnt = entry_count; got.lst = last;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                fails++;
            end
            else
            begin
                want = expected_replies.pop_front();
                if (got.st !== want.st)
                    $display("%0t: status exp %0d got %0d", $realtime, want.st, got.st);
                if (got.ev !== want.ev)
                    $display("%0t: entry_valid exp %0d got %0d", $realtime, want.ev, got.ev);
                if (got.ek !== want.ek)
                    $display("%0t: entry_key exp %h got %h", $realtime, want.ek, got.ek);
                if (got.ep !== want.ep)
                    $display("%0t: entry_pinned exp %0d got %0d", $realtime, want.ep, got.ep);
                if (got.cnt !== want.cnt)
                    $display("%0t: entry_count exp %0d got %0d", $realtime, want.cnt,
                             got.cnt);
                if (got.lst !== want.lst)
                    $display("%0t: last exp %0d got %0d", $realtime, want.lst, got.lst);
                if (got !== want) fails++;
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (expected_replies.size() != 0 && cycles < CYC_LIMIT) @(posedge clk);
        repeat (200) @(posedge clk);
        if (cycles >= CYC_LIMIT)
            $display("lru_table_with_pinning_core_test NOT OK");
        else if (fails == 0 && expected_replies.size() == 0)
            $display("lru_table_with_pinning_core_test OK");
        else
            $display("lru_table_with_pinning_core_test NOT OK");
        $finish;
    end

    // Timeout guard.
    initial
    begin
        wait (cycles >= CYC_LIMIT);
        $display("lru_table_with_pinning_core_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+sv
sv/lrutp_pkg.sv
sv/lru_table_with_pinning_core.sv
bench/lru_table_with_pinning_core_test.sv
